/* sv/brbd_pkg.sv */
`timescale 1ns / 1ps

package brbd_pkg;

    // Sizes fixed by the field formats
    localparam int BYTE_W        = 8;
    localparam int CAP_W         = 9;
    localparam int CAP_MAX       = 256;
    localparam int DEPTH_DEFAULT = 256;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_PULL  = 2'd1,
        FUNC_POP   = 2'd2,
        FUNC_FLUSH = 2'd3
    } t_func;

    // One command transaction
    typedef struct packed {
        t_func               func;
        logic [BYTE_W-1:0]   data_in;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic                accepted;
        logic [BYTE_W-1:0]   data_out;
        logic [CAP_W-1:0]    fill_count;
        logic                is_empty;
        logic                is_full;
    } t_result;

endpackage

/* sv/brbd_mem.sv */
`timescale 1ns / 1ps

module brbd_mem
    import brbd_pkg::*;
#(
    parameter int MEM_DEPTH = DEPTH_DEFAULT,
    parameter int ADDR_W    = $clog2(MEM_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [BYTE_W-1:0]   i_wdata,
    output logic [BYTE_W-1:0]   o_rdata
);

    logic [BYTE_W-1:0] r_cells [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Single port storage, write and registered read at one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_cells[i_addr] <= i_wdata;
        end
        r_rdata <= r_cells[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/brbd_ctrl.sv */
`timescale 1ns / 1ps

module brbd_ctrl
    import brbd_pkg::*;
#(
    parameter int MEM_DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W     = $clog2(MEM_DEPTH),
    parameter int CNT_W     = $clog2(MEM_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_item               i_item,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    output logic                o_mem_we,
    output logic [IDX_W-1:0]    o_mem_addr,
    output logic [BYTE_W-1:0]   o_mem_wdata,
    input  logic [BYTE_W-1:0]   i_mem_rdata,
    output logic                o_strobe,
    output t_result             o_result
);

    localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(MEM_DEPTH);
    localparam logic [IDX_W-1:0] LAST_RST = IDX_W'(MEM_DEPTH - 1);

    // Input register
    logic               r_in_vld;
    t_item              r_item;

    // Ring state
    logic [CNT_W-1:0]   r_cap,   n_cap;
    logic [IDX_W-1:0]   r_last,  n_last;
    logic [IDX_W-1:0]   r_head,  n_head;
    logic [IDX_W-1:0]   r_tail,  n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    // Result register
    logic               r_res_vld;
    logic               r_acc,   n_acc;
    logic               r_rd,    n_rd;
    logic [CNT_W-1:0]   r_fill;
    logic               r_empty;
    logic               r_full;

    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   tail_dec;
    logic [CNT_W-1:0]   cap_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_accept;
        end
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    // Capacity clamped to 1 .. memory depth at write time
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cap_sat = CNT_W'(1);
        end else if (i_cfg_wdata > CAP_W'(MEM_DEPTH)) begin
            cap_sat = CAP_RST;
        end else begin
            cap_sat = CNT_W'(i_cfg_wdata);
        end
    end

    assign full     = (r_count == r_cap);
    assign empty    = (r_count == '0);
    assign tail_dec = (r_tail == '0) ? r_last : r_tail - IDX_W'(1);

    // Operation decode and next state
    always_comb begin
        n_cap       = r_cap;
        n_last      = r_last;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_acc       = 1'b0;
        n_rd        = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_tail;
        o_mem_wdata = r_item.data_in;

        if (i_cfg_we) begin
            // a capacity write also empties the ring
            n_cap   = cap_sat;
            n_last  = IDX_W'(cap_sat - CNT_W'(1));
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (r_in_vld) begin
            case (r_item.func)
                FUNC_PUSH: begin
                    if (!full) begin
                        o_mem_we = 1'b1;
                        n_tail   = (r_tail == r_last) ? '0 : r_tail + IDX_W'(1);
                        n_count  = r_count + CNT_W'(1);
                        n_acc    = 1'b1;
                    end
                end
                FUNC_PULL: begin
                    o_mem_addr = r_head;
                    if (!empty) begin
                        n_head  = (r_head == r_last) ? '0 : r_head + IDX_W'(1);
                        n_count = r_count - CNT_W'(1);
                        n_rd    = 1'b1;
                    end
                end
                FUNC_POP: begin
                    o_mem_addr = tail_dec;
                    if (!empty) begin
                        n_tail  = tail_dec;
                        n_count = r_count - CNT_W'(1);
                        n_rd    = 1'b1;
                    end
                end
                default: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RST;
            r_last    <= LAST_RST;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_cap     <= n_cap;
            r_last    <= n_last;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_res_vld <= r_in_vld & ~i_cfg_we;
        end
        r_acc   <= n_acc;
        r_rd    <= n_rd;
        r_fill  <= n_count;
        r_empty <= (n_count == '0);
        r_full  <= (n_count == n_cap);
    end

    // Read data arrives from the memory register alongside the result
    assign o_strobe            = r_res_vld;
    assign o_result.accepted   = r_acc;
    assign o_result.data_out   = r_rd ? i_mem_rdata : '0;
    assign o_result.fill_count = CAP_W'(r_fill);
    assign o_result.is_empty   = r_empty;
    assign o_result.is_full    = r_full;

endmodule

/* sv/byte_ring_buffer_deque_core.sv */
`timescale 1ns / 1ps

// A command taken at a clock edge goes through the input register, then the state and
// result registers, which raise the result strobe and the accepted flag.
// Throughput: one command per cycle; busy is never raised, and the ring state
// loop (indices, count, one memory port) closes at the state registers.
// Reset (synchronous, active low): ring empty, indices zero, capacity at full depth.
// The receiver cannot stall: each result is presented for exactly one cycle.
module byte_ring_buffer_deque_core
    import brbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_item               i_item,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    output logic                o_strobe,
    output t_result             o_result
);

    // Only the first min(DEPTH, 256) cells can ever be addressed
    localparam int MEM_DEPTH = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MEM_DEPTH + 1);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [BYTE_W-1:0]  mem_rdata;

    // Always ready for a new command
    assign busy = 1'b0;

    brbd_ctrl #(
        .MEM_DEPTH (MEM_DEPTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start & ~busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    brbd_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .ADDR_W    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

/* tb/byte_ring_buffer_deque_core_tb.sv */
`timescale 1ns / 1ps

module byte_ring_buffer_deque_core_tb;
    import brbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int CAP_CEIL = (CAP_MAX < DEPTH_DEFAULT) ? CAP_MAX : DEPTH_DEFAULT;
    localparam int RING_IDX_W = $clog2(DEPTH_DEFAULT);

    // One row of the directed sequence: a capacity write or a command
    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cfg_val;
        t_item            cmd;
        bit               typed;
        t_result          want;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_item            i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata = '0;
    logic             o_strobe;
    t_result          o_result;

    // Shadow of the ring
    logic [BYTE_W-1:0] ring_mem [DEPTH_DEFAULT];
    int unsigned       ring_head = 0;
    int unsigned       ring_tail = 0;
    bit                ring_empty = 1'b1;
    logic [CAP_W-1:0]  ring_cap = CAP_W'(CAP_MAX);

    t_result   pending_results[$];
    t_dir_row  dir_rows[$];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    byte_ring_buffer_deque_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Capacity as the ring actually uses it
    function automatic int unsigned ring_limit();
        int unsigned c;
        c = 32'(ring_cap);
        if (c < 1) c = 1;
        if (c > CAP_CEIL) c = CAP_CEIL;
        return c;
    endfunction

    function automatic void ring_flush();
        ring_head  = 0;
        ring_tail  = 0;
        ring_empty = 1'b1;
    endfunction

    // Apply one command to the shadow ring and return the result it should give
    function automatic t_result ring_apply(input t_item cmd);
        t_result     r;
        int unsigned lim;
        int unsigned held;
        r   = '0;
        lim = ring_limit();
        case (cmd.func)
            FUNC_PUSH: begin
                // refused only when full
                if (ring_empty || ring_head != ring_tail) begin
                    if (ring_empty) begin
                        ring_head  = ring_tail;
                        ring_empty = 1'b0;
                    end
                    ring_mem[RING_IDX_W'(ring_tail)] = cmd.data_in;
                    ring_tail  = (ring_tail + 1 >= lim) ? 0 : ring_tail + 1;
                    r.accepted = 1'b1;
                end
            end
            FUNC_PULL: begin
                if (!ring_empty) begin
                    r.data_out = ring_mem[RING_IDX_W'(ring_head)];
                    ring_head  = (ring_head + 1 >= lim) ? 0 : ring_head + 1;
                    if (ring_head == ring_tail) ring_empty = 1'b1;
                end
            end
            FUNC_POP: begin
                if (!ring_empty) begin
                    ring_tail = (ring_tail == 0) ? lim - 1 : ring_tail - 1;
                    if (ring_head == ring_tail) ring_empty = 1'b1;
                    r.data_out = ring_mem[RING_IDX_W'(ring_tail)];
                end
            end
            default: ring_flush();
        endcase
        if (ring_empty)                held = 0;
        else if (ring_head == ring_tail) held = lim;
        else if (ring_tail > ring_head)  held = ring_tail - ring_head;
        else                             held = lim - (ring_head - ring_tail);
        r.fill_count = CAP_W'(held);
        r.is_empty   = ring_empty;
        r.is_full    = (held == lim);
        return r;
    endfunction

    function automatic t_result mk_result(input logic acc, input logic [BYTE_W-1:0] dout,
                                          input int unsigned held, input logic emp,
                                          input logic full);
        t_result r;
        r.accepted   = acc;
        r.data_out   = dout;
        r.fill_count = CAP_W'(held);
        r.is_empty   = emp;
        r.is_full    = full;
        return r;
    endfunction

    // Directed table builders
    function automatic void dir_cfg(input logic [CAP_W-1:0] val);
        t_dir_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_cmd(input t_func f, input logic [BYTE_W-1:0] d,
                                    input bit typed = 1'b0, input t_result want = '0);
        t_dir_row row;
        row              = '{default: '0};
        row.cmd.func     = f;
        row.cmd.data_in  = d;
        row.typed        = typed;
        row.want         = want;
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // Drive one command transaction, with bursts and gaps, and log its expectation
    task automatic send_command(input t_item cmd, input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = ring_apply(cmd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Capacity writes only once the ring has gone quiet
    task automatic program_capacity(input logic [CAP_W-1:0] val);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        ring_cap = val;
        ring_flush();
        i_cfg_we   <= 1'b0;
        burst_left = 0;
    endtask

    // Random phase at one capacity; push_pct steers how far the ring fills
    task automatic run_phase(input logic [CAP_W-1:0] val, input int n, input int push_pct);
        t_item cmd;
        int    pick;
        program_capacity(val);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)                 cmd.func = FUNC_FLUSH;
            else if (pick < 3 + push_pct) cmd.func = FUNC_PUSH;
            else if (pick[0])             cmd.func = FUNC_PULL;
            else                          cmd.func = FUNC_POP;
            cmd.data_in = BYTE_W'($urandom_range(0, 255));
            send_command(cmd, 1'b0, '0);
        end
    endtask

    // Result checker: oldest expectation first, field by field
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_result), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.accepted !== want.accepted)
                    report_mismatch("accepted", 32'(o_result.accepted),
                                    32'(want.accepted));
                if (o_result.data_out !== want.data_out)
                    report_mismatch("data_out", 32'(o_result.data_out),
                                    32'(want.data_out));
                if (o_result.fill_count !== want.fill_count)
                    report_mismatch("fill_count", 32'(o_result.fill_count),
                                    32'(want.fill_count));
                if (o_result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(o_result.is_empty),
                                    32'(want.is_empty));
                if (o_result.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(o_result.is_full),
                                    32'(want.is_full));
            end
        end
    end

    // Watchdog: too long without any transaction in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Empty ring at reset capacity: underflow, both byte extremes, flush
        dir_cmd(FUNC_PULL, 8'h00, 1'b1, mk_result(1'b0, 8'h00, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_POP, 8'hFF, 1'b1, mk_result(1'b0, 8'h00, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_PUSH, 8'h00, 1'b1, mk_result(1'b1, 8'h00, 1, 1'b0, 1'b0));
        dir_cmd(FUNC_PUSH, 8'hFF, 1'b1, mk_result(1'b1, 8'h00, 2, 1'b0, 1'b0));
        dir_cmd(FUNC_PULL, 8'h00, 1'b1, mk_result(1'b0, 8'h00, 1, 1'b0, 1'b0));
        dir_cmd(FUNC_POP, 8'h00, 1'b1, mk_result(1'b0, 8'hFF, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_PUSH, 8'hA5);
        dir_cmd(FUNC_FLUSH, 8'h00, 1'b1, mk_result(1'b0, 8'h00, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_PUSH, 8'h5A);
        dir_cmd(FUNC_PUSH, 8'hC3);
        dir_cmd(FUNC_FLUSH, 8'hFF, 1'b1, mk_result(1'b0, 8'h00, 0, 1'b1, 1'b0));
        // Zero capacity taken as one: full after a single push, push refused
        dir_cfg(CAP_W'(0));
        dir_cmd(FUNC_PUSH, 8'h11, 1'b1, mk_result(1'b1, 8'h00, 1, 1'b0, 1'b1));
        dir_cmd(FUNC_PUSH, 8'h22, 1'b1, mk_result(1'b0, 8'h00, 1, 1'b0, 1'b1));
        dir_cmd(FUNC_POP, 8'h00, 1'b1, mk_result(1'b0, 8'h11, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_PULL, 8'h00, 1'b1, mk_result(1'b0, 8'h00, 0, 1'b1, 1'b0));
        dir_cmd(FUNC_PUSH, 8'h33);
        dir_cmd(FUNC_PULL, 8'h00);
        // Capacity two: fill, refuse, wrap the tail index both ways
        dir_cfg(CAP_W'(2));
        dir_cmd(FUNC_PUSH, 8'h81);
        dir_cmd(FUNC_PUSH, 8'h42);
        dir_cmd(FUNC_PUSH, 8'h24, 1'b1, mk_result(1'b0, 8'h00, 2, 1'b0, 1'b1));
        dir_cmd(FUNC_PULL, 8'h00);
        dir_cmd(FUNC_PUSH, 8'h18);
        dir_cmd(FUNC_POP, 8'h00);
        dir_cmd(FUNC_POP, 8'h00);
        dir_cmd(FUNC_PULL, 8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) program_capacity(dir_rows[k].cfg_val);
            else send_command(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases over a spread of capacities, extremes included
        run_phase(CAP_W'(3), 120, 50);
        run_phase(CAP_W'(256), 330, 85);
        run_phase(CAP_W'(1), 100, 50);
        run_phase(CAP_W'(511), 130, 55);
        run_phase(CAP_W'(0), 80, 50);
        run_phase(CAP_W'($urandom_range(4, 40)), 140, 55);
        run_phase(CAP_W'(300), 120, 50);
        run_phase(CAP_W'($urandom_range(1, 256)), 140, 60);
        run_phase(CAP_W'(2), 100, 50);
        run_phase(CAP_W'($urandom_range(257, 511)), 140, 45);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
